FILE: rtl/alac_pkg.sv
// shared types, constants and calibration table for the angle calibration block
package alac_pkg;

    // word field widths
    localparam int SAMPLE_W = 12;
    localparam int ANGLE_W  = 11;
    localparam int WEIGHT_W = 7;
    localparam int SELECT_W = 2;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_WEIGHT = 1'b0;
    localparam logic REG_SELECT = 1'b1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 7'd85;
    localparam logic [SELECT_W-1:0] SELECT_RESET = 2'd2;

    // angle select codes
    localparam logic [SELECT_W-1:0] SEL_AVG  = 2'd0;
    localparam logic [SELECT_W-1:0] SEL_FILT = 2'd1;
    localparam logic [SELECT_W-1:0] SEL_BOTH = 2'd2;

    // filter arithmetic
    localparam logic [SAMPLE_W-1:0] RAW_CEIL = 12'd4080;
    localparam logic [WEIGHT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [WEIGHT_W-1:0] PCT_HALF = 7'd50;
    localparam logic [3:0]          TENTHS   = 4'd10;
    localparam int MIX_W       = 19;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = MIX_W + RECIP_W;
    // ceil(2^26 / 100): exact quotient for every mix value below 2^19
    localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

    // calibration table, raw descending
    localparam int CAL_POINTS = 19;
    localparam int CAL_IDX_W  = $clog2(CAL_POINTS);
    localparam logic [SAMPLE_W-1:0] CAL_RAW [CAL_POINTS] = '{
        12'd3943, 12'd3746, 12'd3575, 12'd3386, 12'd3199, 12'd3006, 12'd2811,
        12'd2602, 12'd2396, 12'd2192, 12'd1977, 12'd1761, 12'd1560, 12'd1366,
        12'd1148, 12'd950,  12'd707,  12'd509,  12'd285
    };
    localparam logic [7:0] CAL_DEG [CAL_POINTS] = '{
        8'd0,   8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd60,  8'd70,  8'd80,
        8'd90,  8'd100, 8'd110, 8'd120, 8'd130, 8'd140, 8'd150, 8'd160, 8'd170,
        8'd180
    };
    localparam logic [ANGLE_W-1:0] ANGLE_FIRST =
        ANGLE_W'(CAL_DEG[0]) * ANGLE_W'(TENTHS);
    localparam logic [ANGLE_W-1:0] ANGLE_LAST =
        ANGLE_W'(CAL_DEG[CAL_POINTS-1]) * ANGLE_W'(TENTHS);

    // interpolation divider
    localparam int DIV_NUM_W = 15;
    localparam int DIV_DEN_W = 8;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic mix;
        logic recip;
        logic filt;
        logic setup;
        logic emit;
    } alac_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
    } alac_stat_t;

    // segment lookup result for one raw value
    typedef struct packed {
        logic                 hi_sat;
        logic                 lo_sat;
        logic [ANGLE_W-1:0]   base;
        logic [DIV_DEN_W-1:0] span;
        logic [DIV_NUM_W-1:0] dividend;
    } alac_seg_t;

    // find the table segment holding raw and build the rounded division operands
    function automatic alac_seg_t cal_setup(input logic [SAMPLE_W-1:0] raw);
        alac_seg_t             seg;
        logic [CAL_IDX_W-1:0]  idx;
        logic [CAL_IDX_W-1:0]  nxt;
        logic [SAMPLE_W-1:0]   span_full;
        logic [SAMPLE_W-1:0]   off_full;
        logic [ANGLE_W-1:0]    dspan;
        idx = '0;
        for (int k = CAL_POINTS - 2; k >= 0; k--)
        begin
            if (raw >= CAL_RAW[k+1])
            begin
                idx = CAL_IDX_W'(k);
            end
        end
        nxt       = idx + CAL_IDX_W'(1);
        span_full = CAL_RAW[idx] - CAL_RAW[nxt];
        off_full  = CAL_RAW[idx] - raw;
        dspan     = ANGLE_W'(CAL_DEG[nxt] - CAL_DEG[idx]) * ANGLE_W'(TENTHS);
        seg.hi_sat   = (raw >= CAL_RAW[0]);
        seg.lo_sat   = (raw <= CAL_RAW[CAL_POINTS-1]);
        seg.base     = ANGLE_W'(CAL_DEG[idx]) * ANGLE_W'(TENTHS);
        seg.span     = span_full[DIV_DEN_W-1:0];
        seg.dividend = DIV_NUM_W'(off_full[DIV_DEN_W-1:0]) * DIV_NUM_W'(dspan)
                     + DIV_NUM_W'(span_full[DIV_DEN_W-1:1]);
        return seg;
    endfunction

endpackage

FILE: rtl/alac_if.sv
// valid/ready channel interfaces for sample and result words

interface alac_sample_if
    import alac_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] averaged_sample;

    modport source (output valid, output averaged_sample, input ready);
    modport sink   (input valid, input averaged_sample, output ready);
endinterface

interface alac_result_if
    import alac_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] clamped_average;
    logic [SAMPLE_W-1:0] filtered_sample;
    logic [ANGLE_W-1:0]  average_angle_tenths;
    logic [ANGLE_W-1:0]  filtered_angle_tenths;
    logic                average_angle_valid;
    logic                filtered_angle_valid;

    modport source (
        output valid, output clamped_average, output filtered_sample,
        output average_angle_tenths, output filtered_angle_tenths,
        output average_angle_valid, output filtered_angle_valid,
        input ready
    );
    modport sink (
        input valid, input clamped_average, input filtered_sample,
        input average_angle_tenths, input filtered_angle_tenths,
        input average_angle_valid, input filtered_angle_valid,
        output ready
    );
endinterface

FILE: rtl/alac_cfg_regs.sv
// configuration registers behind the apb-style port
module alac_cfg_regs
    import alac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [WEIGHT_W-1:0]   weight,
    output logic [SELECT_W-1:0]   select
);

    logic [WEIGHT_W-1:0] weight_reg;
    logic [WEIGHT_W-1:0] weight_next;
    logic [SELECT_W-1:0] select_reg;
    logic [SELECT_W-1:0] select_next;
    logic                wr_en;
    logic                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // register write decode
    always_comb
    begin
        weight_next = weight_reg;
        select_next = select_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_WEIGHT: weight_next = pwdata[WEIGHT_W-1:0];
                REG_SELECT: select_next = pwdata[SELECT_W-1:0];
                default:    weight_next = weight_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            select_reg <= SELECT_RESET;
        end
        else
        begin
            weight_reg <= weight_next;
            select_reg <= select_next;
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_idx)
            REG_WEIGHT: prdata = APB_DATA_W'(weight_reg);
            REG_SELECT: prdata = APB_DATA_W'(select_reg);
            default:    prdata = '0;
        endcase
    end

    assign weight = weight_reg;
    assign select = select_reg;

endmodule

FILE: rtl/alac_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
module alac_divider
    import alac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic [DIV_NUM_W-1:0] quotient,
    output logic                 done
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] rem_next;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_NUM_W-1:0] quo_next;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] den_next;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    // one shift-subtract step
    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        done_next = busy_reg && (cnt_reg == CNT_LAST);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: rtl/alac_datapath.sv
// filter arithmetic, calibration lookup and output word register
module alac_datapath
    import alac_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  alac_cmd_t           cmd,
    output alac_stat_t          stat,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [WEIGHT_W-1:0] weight,
    input  logic [SELECT_W-1:0] select,
    output logic [SAMPLE_W-1:0] clamped_average,
    output logic [SAMPLE_W-1:0] filtered_sample,
    output logic [ANGLE_W-1:0]  average_angle_tenths,
    output logic [ANGLE_W-1:0]  filtered_angle_tenths,
    output logic                average_angle_valid,
    output logic                filtered_angle_valid
);

    localparam int QUO_W = PROD_W - RECIP_SHIFT;

    logic                primed_reg;
    logic                primed_next;
    logic [SAMPLE_W-1:0] filt_reg;
    logic [SAMPLE_W-1:0] filt_next;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [SAMPLE_W-1:0] avg_next;
    logic [WEIGHT_W-1:0] w_reg;
    logic [WEIGHT_W-1:0] w_next;
    logic [MIX_W-1:0]    mix_reg;
    logic [MIX_W-1:0]    mix_next;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [QUO_W-1:0]    pct_quo;
    logic [SAMPLE_W-1:0] pct_clamped;

    alac_seg_t           seg_avg;
    alac_seg_t           seg_filt;
    logic                a_hi_reg;
    logic                a_hi_next;
    logic                a_lo_reg;
    logic                a_lo_next;
    logic [ANGLE_W-1:0]  a_base_reg;
    logic [ANGLE_W-1:0]  a_base_next;
    logic                f_hi_reg;
    logic                f_hi_next;
    logic                f_lo_reg;
    logic                f_lo_next;
    logic [ANGLE_W-1:0]  f_base_reg;
    logic [ANGLE_W-1:0]  f_base_next;

    logic [DIV_NUM_W-1:0] a_quo;
    logic [DIV_NUM_W-1:0] f_quo;
    logic                 a_done;
    logic                 f_done;
    logic [ANGLE_W-1:0]   a_angle;
    logic [ANGLE_W-1:0]   f_angle;

    logic [SAMPLE_W-1:0] out_avg_reg;
    logic [SAMPLE_W-1:0] out_avg_next;
    logic [SAMPLE_W-1:0] out_filt_reg;
    logic [SAMPLE_W-1:0] out_filt_next;
    logic [ANGLE_W-1:0]  out_a_ang_reg;
    logic [ANGLE_W-1:0]  out_a_ang_next;
    logic [ANGLE_W-1:0]  out_f_ang_reg;
    logic [ANGLE_W-1:0]  out_f_ang_next;
    logic                out_a_vld_reg;
    logic                out_a_vld_next;
    logic                out_f_vld_reg;
    logic                out_f_vld_next;

    // divide by one hundred through the reciprocal product
    assign pct_quo     = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign pct_clamped = (pct_quo > QUO_W'(RAW_CEIL)) ? RAW_CEIL : pct_quo[SAMPLE_W-1:0];

    // segment lookup for both values
    assign seg_avg  = cal_setup(avg_reg);
    assign seg_filt = cal_setup(filt_reg);

    // filter pipeline steps
    always_comb
    begin
        avg_next    = avg_reg;
        w_next      = w_reg;
        mix_next    = mix_reg;
        prod_next   = prod_reg;
        filt_next   = filt_reg;
        primed_next = primed_reg;
        if (cmd.load)
        begin
            avg_next = (sample > RAW_CEIL) ? RAW_CEIL : sample;
            w_next   = (weight > PCT_FULL) ? PCT_FULL : weight;
        end
        if (cmd.mix)
        begin
            mix_next = MIX_W'(w_reg) * MIX_W'(avg_reg)
                     + MIX_W'(PCT_FULL - w_reg) * MIX_W'(filt_reg)
                     + MIX_W'(PCT_HALF);
        end
        if (cmd.recip)
        begin
            prod_next = PROD_W'(mix_reg) * PROD_W'(RECIP_100);
        end
        if (cmd.filt)
        begin
            filt_next   = primed_reg ? pct_clamped : avg_reg;
            primed_next = 1'b1;
        end
    end

    // segment capture for the angle conversion
    always_comb
    begin
        a_hi_next   = a_hi_reg;
        a_lo_next   = a_lo_reg;
        a_base_next = a_base_reg;
        f_hi_next   = f_hi_reg;
        f_lo_next   = f_lo_reg;
        f_base_next = f_base_reg;
        if (cmd.setup)
        begin
            a_hi_next   = seg_avg.hi_sat;
            a_lo_next   = seg_avg.lo_sat;
            a_base_next = seg_avg.base;
            f_hi_next   = seg_filt.hi_sat;
            f_lo_next   = seg_filt.lo_sat;
            f_base_next = seg_filt.base;
        end
    end

    alac_divider u_div_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.setup),
        .dividend (seg_avg.dividend),
        .divisor  (seg_avg.span),
        .quotient (a_quo),
        .done     (a_done)
    );

    alac_divider u_div_filt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.setup),
        .dividend (seg_filt.dividend),
        .divisor  (seg_filt.span),
        .quotient (f_quo),
        .done     (f_done)
    );

    assign stat.div_done = a_done && f_done;

    // saturate outside the table, else segment base plus rounded offset
    assign a_angle = a_hi_reg ? ANGLE_FIRST :
                     a_lo_reg ? ANGLE_LAST  : a_base_reg + a_quo[ANGLE_W-1:0];
    assign f_angle = f_hi_reg ? ANGLE_FIRST :
                     f_lo_reg ? ANGLE_LAST  : f_base_reg + f_quo[ANGLE_W-1:0];

    // output word register
    always_comb
    begin
        out_avg_next   = out_avg_reg;
        out_filt_next  = out_filt_reg;
        out_a_ang_next = out_a_ang_reg;
        out_f_ang_next = out_f_ang_reg;
        out_a_vld_next = out_a_vld_reg;
        out_f_vld_next = out_f_vld_reg;
        if (cmd.emit)
        begin
            out_avg_next   = avg_reg;
            out_filt_next  = filt_reg;
            out_a_ang_next = a_angle;
            out_f_ang_next = f_angle;
            out_a_vld_next = (select == SEL_AVG) || (select == SEL_BOTH);
            out_f_vld_next = (select == SEL_FILT) || (select == SEL_BOTH);
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            filt_reg   <= '0;
        end
        else
        begin
            primed_reg <= primed_next;
            filt_reg   <= filt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        avg_reg       <= avg_next;
        w_reg         <= w_next;
        mix_reg       <= mix_next;
        prod_reg      <= prod_next;
        a_hi_reg      <= a_hi_next;
        a_lo_reg      <= a_lo_next;
        a_base_reg    <= a_base_next;
        f_hi_reg      <= f_hi_next;
        f_lo_reg      <= f_lo_next;
        f_base_reg    <= f_base_next;
        out_avg_reg   <= out_avg_next;
        out_filt_reg  <= out_filt_next;
        out_a_ang_reg <= out_a_ang_next;
        out_f_ang_reg <= out_f_ang_next;
        out_a_vld_reg <= out_a_vld_next;
        out_f_vld_reg <= out_f_vld_next;
    end

    assign clamped_average       = out_avg_reg;
    assign filtered_sample       = out_filt_reg;
    assign average_angle_tenths  = out_a_ang_reg;
    assign filtered_angle_tenths = out_f_ang_reg;
    assign average_angle_valid   = out_a_vld_reg;
    assign filtered_angle_valid  = out_f_vld_reg;

endmodule

FILE: rtl/alac_ctrl.sv
// sequencing state machine and output valid flag
module alac_ctrl
    import alac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output alac_cmd_t  cmd,
    input  alac_stat_t stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MIX   = 3'd1;
    localparam logic [2:0] ST_RECIP = 3'd2;
    localparam logic [2:0] ST_FILT  = 3'd3;
    localparam logic [2:0] ST_SETUP = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MIX;
                end
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.filt   = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output word held until taken
    assign out_valid_next = (out_valid_reg && !out_ready) || cmd.emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/adc_lowpass_angle_calibration_unit.sv
// Potentiometer angle front end: each sample word is clamped to 0..4080, fed
// through a percent-weighted low-pass filter (loaded directly by the first
// sample after reset) and both the clamped and the filtered value are turned
// into tenths of a degree by rounded interpolation over a 19-point table.
// One word is in work at a time: a sample is carried from acceptance through
// the load, mix, reciprocal multiply, filter update and segment lookup steps,
// the pair of 15-step restoring dividers that do the interpolation rounding
// and the result load, and the next sample is taken on the cycle after that.
// A finished word waits in the output register while the next sample is
// processed; a result that is not taken stalls the sequencer only at the
// result load of the next word. The filter
// weight and the angle select are set through the apb-style port at byte
// addresses 0 and 4.
module adc_lowpass_angle_calibration_unit
    import alac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    alac_sample_if.sink           sample_ch,
    alac_result_if.source         result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [WEIGHT_W-1:0] weight;
    logic [SELECT_W-1:0] select;
    alac_cmd_t           cmd;
    alac_stat_t          stat;
    logic                in_ready;
    logic                out_valid;

    // configuration registers
    alac_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .weight  (weight),
        .select  (select)
    );

    // sequencer
    alac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // arithmetic and output word
    alac_datapath u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .stat                  (stat),
        .sample                (sample_ch.averaged_sample),
        .weight                (weight),
        .select                (select),
        .clamped_average       (result_ch.clamped_average),
        .filtered_sample       (result_ch.filtered_sample),
        .average_angle_tenths  (result_ch.average_angle_tenths),
        .filtered_angle_tenths (result_ch.filtered_angle_tenths),
        .average_angle_valid   (result_ch.average_angle_valid),
        .filtered_angle_valid  (result_ch.filtered_angle_valid)
    );

    assign sample_ch.ready = in_ready;
    assign result_ch.valid = out_valid;

endmodule
